>>> rtl/ptt_pkg.sv
// ptt_pkg: shared codes and command/status structs for the periodic timer table.
// No dependencies; imported by the controller, the datapath and the checker.
package ptt_pkg;

    localparam int unsigned CountW = 7;

    // Input command codes
    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_DEL  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_DELETED = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;
    localparam logic [2:0] ST_FIRED   = 3'd5;
    localparam logic [2:0] ST_NONE    = 3'd6;

    // Source of the slot_id field of a result
    typedef enum logic [1:0] {
        ID_ZERO,
        ID_IDX,
        ID_SLOT,
        ID_PEND
    } id_sel_t;

    typedef struct packed {
        logic       cap;       // take the input item
        logic       idx_clr;   // scan index to slot 0
        logic       idx_inc;   // scan index to the next slot
        logic       rd_en;     // read period/due at the next scan address
        logic       add_wr;    // claim slot at scan index
        logic       del_do;    // free the requested slot
        logic       fire_wr;   // rearm slot at scan index
        logic       pend_set;  // hold scan index as pending fired slot
        logic       pend_clr;
        logic       out_load;  // load the result register
        logic [2:0] out_st;
        id_sel_t    out_id;
        logic       out_last;
    } ptt_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       period_zero;
        logic       idx_last;
        logic       slot_free;
        logic       fire;
        logic       del_hit;
        logic       pend_valid;
        logic       out_free;
    } ptt_stat_t;

endpackage

>>> rtl/periodic_timer_table_core.sv
// periodic_timer_table_core: top level of the periodic timer table.
// Depends on ptt_pkg, ptt_ctrl and ptt_datapath.
//
// A table of SLOTS periodic timers, one command per input item, one at a time.
// Add (mode 0) scans slots from 0 for the first free one, one slot a cycle,
// and answers with the index of that slot, or with a full status when no
// slot is free. Delete (mode 1) and a zero-interval add answer without a
// scan. Tick (mode 2) loads the time and walks every slot through the
// registered read port of the due/period memories, one slot a cycle unless
// a backed-up result channel holds the walk. Fired slots come out in slot
// order, the final one flagged with m_last; a tick that fires nothing gives
// one "none fired" item. New input is taken only when the previous item's
// results are all queued. Due and period memories need no clearing: values
// read for slots not marked active are ignored.
module periodic_timer_table_core #(
    parameter int unsigned SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [5:0]  s_slot,
    input  logic [31:0] s_period,
    input  logic [63:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [5:0]  m_slot_id,
    output logic [6:0]  m_active_count,
    output logic        m_last
);
    import ptt_pkg::*;

    ptt_cmd_t  cmd;   // controller to datapath
    ptt_stat_t stat;  // datapath to controller

    ptt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptt_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_mode         (s_mode),
        .s_slot         (s_slot),
        .s_period       (s_period),
        .s_now_time     (s_now_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot_id      (m_slot_id),
        .m_active_count (m_active_count),
        .m_last         (m_last)
    );

endmodule

>>> rtl/ptt_ctrl.sv
// ptt_ctrl: sequencing state machine for the periodic timer table.
// Depends on ptt_pkg; drives ptt_datapath through ptt_cmd_t.
module ptt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ptt_pkg::ptt_stat_t stat,
    output ptt_pkg::ptt_cmd_t  cmd
);
    import ptt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ZERO,
        S_ASCAN,
        S_DEL,
        S_TSCAN,
        S_TFIN
    } state_t;

    state_t state_reg, state_next;
    logic   adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    // a fired slot may move on unless it must push out an earlier one first
    assign adv     = !stat.fire || !stat.pend_valid || stat.out_free;

    always_comb begin
        cmd        = '0;
        cmd.out_id = ID_ZERO;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.cap    = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.mode)
                    MODE_ADD: begin
                        cmd.idx_clr = 1'b1;
                        state_next  = stat.period_zero ? S_ZERO : S_ASCAN;
                    end
                    MODE_DEL:  state_next = S_DEL;
                    MODE_TICK: begin
                        cmd.idx_clr  = 1'b1;
                        cmd.rd_en    = 1'b1;
                        cmd.pend_clr = 1'b1;
                        state_next   = S_TSCAN;
                    end
                    default:   state_next = S_IDLE;
                endcase
            end
            S_ZERO: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_st   = ST_ZERO;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_ASCAN: begin
                if (stat.slot_free) begin
                    if (stat.out_free) begin
                        cmd.add_wr   = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_st   = ST_ADDED;
                        cmd.out_id   = ID_IDX;
                        cmd.out_last = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else if (stat.idx_last) begin
                    if (stat.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_st   = ST_FULL;
                        cmd.out_last = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_DEL: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_id   = ID_SLOT;
                    cmd.out_last = 1'b1;
                    cmd.del_do   = stat.del_hit;
                    cmd.out_st   = stat.del_hit ? ST_DELETED : ST_IDLE;
                    state_next   = S_IDLE;
                end
            end
            S_TSCAN: begin
                if (adv) begin
                    if (stat.fire) begin
                        cmd.fire_wr  = 1'b1;
                        cmd.pend_set = 1'b1;
                        if (stat.pend_valid) begin
                            cmd.out_load = 1'b1;
                            cmd.out_st   = ST_FIRED;
                            cmd.out_id   = ID_PEND;
                        end
                    end
                    if (stat.idx_last) begin
                        state_next = S_TFIN;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                    end
                end
            end
            S_TFIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    if (stat.pend_valid) begin
                        cmd.out_st = ST_FIRED;
                        cmd.out_id = ID_PEND;
                    end else begin
                        cmd.out_st = ST_NONE;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> rtl/ptt_datapath.sv
// ptt_datapath: slot memories, active bits, time, count and result register.
// Depends on ptt_pkg; commanded by ptt_ctrl.
module ptt_datapath #(
    parameter int unsigned SLOTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ptt_pkg::ptt_cmd_t  cmd,
    output ptt_pkg::ptt_stat_t stat,
    input  logic [1:0]         s_mode,
    input  logic [5:0]         s_slot,
    input  logic [31:0]        s_period,
    input  logic [63:0]        s_now_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [5:0]         m_slot_id,
    output logic [6:0]         m_active_count,
    output logic               m_last
);
    import ptt_pkg::*;

    localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [1:0]        mode_reg;
    logic [5:0]        slot_reg;
    logic [31:0]       period_reg;
    logic [63:0]       cur_time_reg;
    logic [CountW-1:0] live_reg, live_next;
    logic [SLOTS-1:0]  active_reg;
    logic [IdxW-1:0]   idx_reg, rd_addr, slot_idx, pend_id_reg;
    logic              pend_valid_reg;

    logic [31:0] period_mem [SLOTS];
    logic [63:0] due_mem [SLOTS];
    logic [31:0] period_rd_reg;
    logic [63:0] due_rd_reg;
    logic [63:0] due_sum;

    logic              m_valid_reg;
    logic [2:0]        m_status_reg;
    logic [5:0]        m_slot_id_reg;
    logic [CountW-1:0] m_count_reg;
    logic              m_last_reg;
    logic [5:0]        id_mux;
    logic              slot_in_range;

    assign rd_addr       = cmd.idx_clr ? '0 : idx_reg + 1'b1;
    assign slot_idx      = slot_reg[IdxW-1:0];
    assign slot_in_range = ({1'b0, slot_reg} < 7'(SLOTS));
    assign due_sum       = cur_time_reg + {32'd0, (cmd.add_wr ? period_reg : period_rd_reg)};

    always_comb begin
        live_next = live_reg;
        if (cmd.add_wr) live_next = live_reg + 1'b1;
        if (cmd.del_do) live_next = live_reg - 1'b1;
    end

    assign stat.mode        = mode_reg;
    assign stat.period_zero = (period_reg == 32'd0);
    assign stat.idx_last    = (idx_reg == IdxW'(SLOTS - 1));
    assign stat.slot_free   = !active_reg[idx_reg];
    assign stat.fire        = active_reg[idx_reg] && (cur_time_reg >= due_rd_reg);
    assign stat.del_hit     = slot_in_range && active_reg[slot_idx];
    assign stat.pend_valid  = pend_valid_reg;
    assign stat.out_free    = !m_valid_reg || m_ready;

    // item capture, time, count, active bits, scan index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_time_reg   <= '0;
            live_reg       <= '0;
            active_reg     <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cmd.cap && (s_mode == MODE_TICK)) cur_time_reg <= s_now_time;
            live_reg <= live_next;
            if (cmd.add_wr) active_reg[idx_reg]  <= 1'b1;
            if (cmd.del_do) active_reg[slot_idx] <= 1'b0;
            if (cmd.idx_clr)      idx_reg <= '0;
            else if (cmd.idx_inc) idx_reg <= idx_reg + 1'b1;
            if (cmd.pend_set)      pend_valid_reg <= 1'b1;
            else if (cmd.pend_clr) pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            mode_reg   <= s_mode;
            slot_reg   <= s_slot;
            period_reg <= s_period;
        end
        if (cmd.pend_set) pend_id_reg <= idx_reg;
    end

    // slot memories: one write port, one registered read port each
    always_ff @(posedge aclk) begin
        if (cmd.add_wr) period_mem[idx_reg] <= period_reg;
        if (cmd.add_wr || cmd.fire_wr) due_mem[idx_reg] <= due_sum;
        if (cmd.rd_en) begin
            period_rd_reg <= period_mem[rd_addr];
            due_rd_reg    <= due_mem[rd_addr];
        end
    end

    always_comb begin
        case (cmd.out_id)
            ID_IDX:  id_mux = 6'(idx_reg);
            ID_SLOT: id_mux = slot_reg;
            ID_PEND: id_mux = 6'(pend_id_reg);
            default: id_mux = 6'd0;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg  <= cmd.out_st;
            m_slot_id_reg <= id_mux;
            m_count_reg   <= live_next;
            m_last_reg    <= cmd.out_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot_id      = m_slot_id_reg;
    assign m_active_count = m_count_reg;
    assign m_last         = m_last_reg;

endmodule

>>> rtl/ptt_checker.sv
// ptt_checker: port-level assertions for periodic_timer_table_core, and its bind.
// Depends on ptt_pkg.
module ptt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_mode,
    input logic [5:0]  s_slot,
    input logic [31:0] s_period,
    input logic [63:0] s_now_time,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [5:0]  m_slot_id,
    input logic [6:0]  m_active_count,
    input logic        m_last
);
    import ptt_pkg::*;

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_mode) && $stable(s_slot)
            && $stable(s_period) && $stable(s_now_time))
        else $error("input item changed while stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot_id)
            && $stable(m_active_count) && $stable(m_last))
        else $error("result item changed while stalled");

    // a burst of fired items is in flight: no new command may be taken
    a_no_take_mid_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready && (m_status == ST_FIRED))
        else $error("input taken or bad status inside a fired burst");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind periodic_timer_table_core ptt_checker u_ptt_checker (.*);
